[sv/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the buffer hit deframer
// Phase codes, record kinds, fault codes, the result record and the bundle
// that the parser hands to the result queue.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Header and event constants (values as swapped, except the type word).
  localparam logic [15:0] BUF_TYPE     = 16'h0200;
  localparam logic [15:0] MARKER_MASK  = 16'hdf00;
  localparam logic [15:0] MARKER_VALUE = 16'h5500;
  localparam logic [15:0] CLOCK_LEN    = 16'h000c;
  localparam logic [15:0] ID_CLOCK     = 16'h0001;
  localparam logic [7:0]  ID_SYNC      = 8'h11;
  localparam logic [7:0]  ID_SCALER    = 8'h12;
  localparam logic [7:0]  ID_SKIP70    = 8'h70;
  localparam logic [7:0]  ID_SKIP74    = 8'h74;
  localparam logic [7:0]  ID_HIT       = 8'h75;
  localparam logic [7:0]  ID_START     = 8'haa;
  localparam logic [11:0] LOW12_MASK   = 12'hfff;

  // Walk phases of the parser.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_HEAD   = 5'd1,
    PH_LEN    = 5'd2,
    PH_ID     = 5'd3,
    PH_CLK0   = 5'd4,
    PH_CLK1   = 5'd5,
    PH_CLK2   = 5'd6,
    PH_CLK3   = 5'd7,
    PH_SKIP   = 5'd8,
    PH_EVN0   = 5'd9,
    PH_EVN1   = 5'd10,
    PH_T0     = 5'd11,
    PH_T1     = 5'd12,
    PH_T2     = 5'd13,
    PH_T3     = 5'd14,
    PH_USM    = 5'd15,
    PH_UST    = 5'd16,
    PH_GMARK  = 5'd17,
    PH_GMASK  = 5'd18,
    PH_IMARK  = 5'd19,
    PH_IWORD  = 5'd20,
    PH_IMARK2 = 5'd21,
    PH_IWORD2 = 5'd22
  } phase_e;

  // Record kinds.
  typedef enum logic [2:0] {
    KIND_GE_HIT   = 3'd0,
    KIND_SI_HIT   = 3'd1,
    KIND_EVENT    = 3'd2,
    KIND_CLOCK    = 3'd3,
    KIND_ERROR    = 3'd4,
    KIND_BUF_DONE = 3'd5
  } kind_e;

  // Fault codes.
  typedef enum logic [3:0] {
    ERR_ODD_USED       = 4'd0,
    ERR_BUF_TYPE       = 4'd1,
    ERR_ZERO_LEN       = 4'd2,
    ERR_ODD_LEN        = 4'd3,
    ERR_CLOCK_LEN      = 4'd4,
    ERR_UNKNOWN_ID     = 4'd5,
    ERR_US_MARKER      = 4'd6,
    ERR_GE_MASK_MARKER = 4'd7,
    ERR_GE_EN_MARKER   = 4'd8,
    ERR_GE_TIME_MARKER = 4'd9,
    ERR_SI1_MASK       = 4'd10,
    ERR_SI1_ITEM       = 4'd11,
    ERR_SI2_MASK       = 4'd12,
    ERR_SI2_ITEM       = 4'd13,
    ERR_SI3_MASK       = 4'd14,
    ERR_SI3_ITEM       = 4'd15
  } err_e;

  // One result record.
  typedef struct packed {
    logic [2:0]  record_kind;
    logic [5:0]  detector_id;
    logic [15:0] energy;
    logic [11:0] hit_time;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [63:0] event_stamp;
    logic [15:0] micro_time;
    logic [3:0]  error_code;
    logic [15:0] error_position;
    logic [15:0] event_count;
    logic        last_of_run;
  } rec_t;

  // Records produced by one parse step, slot0 first.
  typedef struct packed {
    logic [1:0] count;
    rec_t       slot0;
    rec_t       slot1;
  } push_t;

  // A marker word must carry 0x55 in its high byte, bit 13 ignored.
  function automatic logic marker_ok(logic [15:0] w);
    return (w & MARKER_MASK) == MARKER_VALUE;
  endfunction

  // Fault code for a bad mask marker, by group.
  function automatic err_e mask_code(logic [1:0] grp);
    err_e code;
    unique case (grp)
      2'd0: code = ERR_GE_MASK_MARKER;
      2'd1: code = ERR_SI1_MASK;
      2'd2: code = ERR_SI2_MASK;
      default: code = ERR_SI3_MASK;
    endcase
    return code;
  endfunction

  // Fault code for a bad item marker, by group.
  function automatic err_e item_code(logic [1:0] grp);
    err_e code;
    unique case (grp)
      2'd0: code = ERR_GE_EN_MARKER;
      2'd1: code = ERR_SI1_ITEM;
      2'd2: code = ERR_SI2_ITEM;
      default: code = ERR_SI3_ITEM;
    endcase
    return code;
  endfunction

endpackage

[sv/dfr_result_fifo.sv]
// ----------------------------------------------------------------------------
// dfr_result_fifo: result record queue
// Takes up to two records per cycle from the parser and hands one record per
// cycle to the output side while it is popped. The head entry drives the output directly.
// ----------------------------------------------------------------------------
module dfr_result_fifo
  import dfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  input  logic             pop_i,
  output rec_t             head_o,
  output logic [CNT_W-1:0] count_o
);

  rec_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] tail_next;

  // Pointer and fill bookkeeping.
  always_comb begin
    tail_next = tail_q + PTR_W'(1);
    tail_d    = tail_q + PTR_W'(push_i.count);
    head_d    = pop_i ? head_q + PTR_W'(1) : head_q;
    count_d   = count_q + CNT_W'(push_i.count) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Record storage; the second slot lands one entry past the first.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[tail_q] <= push_i.slot0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[tail_next] <= push_i.slot1;
    end
  end

  assign head_o  = mem_q[head_q];
  assign count_o = count_q;

  // The parser only steps when two entries are free.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W+1)'(count_q) + (CNT_W+1)'(push_i.count)
      <= (CNT_W+1)'(FIFO_DEPTH) + (CNT_W+1)'(pop_i))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("result queue popped while empty");

endmodule

[sv/dfr_parser.sv]
// ----------------------------------------------------------------------------
// dfr_parser: buffer walk state machine
// Byte swaps one buffer word per step, advances the walk through header and
// events, and produces up to two result records for that word.
// ----------------------------------------------------------------------------
module dfr_parser
  import dfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [15:0] raw_word_i,
  input  logic        first_word_i,
  input  logic        final_word_i,
  output push_t       push_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] word_index_q, word_index_d;
  logic [15:0] used_words_q, used_words_d;
  logic [15:0] skip_left_q, skip_left_d;
  logic [15:0] hit_mask_q, hit_mask_d;
  logic [1:0]  mask_group_q, mask_group_d;
  logic [15:0] held_energy_q, held_energy_d;
  logic [31:0] held_evn_q, held_evn_d;
  logic [63:0] held_time_q, held_time_d;
  logic [15:0] held_us_q, held_us_d;
  logic [31:0] held_clock_q, held_clock_d;
  logic [31:0] held_bufnum_q, held_bufnum_d;
  logic [15:0] events_done_q, events_done_d;
  logic        pending_q, pending_d;

  logic [15:0] w;
  logic [15:0] cur_pos;
  logic [15:0] skip_n;
  logic [1:0]  grp_m1;
  logic [1:0]  n;
  rec_t        recs [2];
  rec_t        tmp;
  logic        bnd;
  logic        item_done;
  logic        next_grp;
  logic        flt;
  err_e        flt_code;
  logic [15:0] flt_pos;

  // Blank record of a kind, tagged with the completed event count.
  function automatic rec_t base_rec(kind_e kind, logic [15:0] cnt);
    rec_t r;
    r             = '0;
    r.record_kind = kind;
    r.event_count = cnt;
    return r;
  endfunction

  // One walk step for the word in the input register.
  always_comb begin
    phase_d       = phase_q;
    word_index_d  = word_index_q;
    used_words_d  = used_words_q;
    skip_left_d   = skip_left_q;
    hit_mask_d    = hit_mask_q;
    mask_group_d  = mask_group_q;
    held_energy_d = held_energy_q;
    held_evn_d    = held_evn_q;
    held_time_d   = held_time_q;
    held_us_d     = held_us_q;
    held_clock_d  = held_clock_q;
    held_bufnum_d = held_bufnum_q;
    events_done_d = events_done_q;
    pending_d     = pending_q;

    w         = {raw_word_i[7:0], raw_word_i[15:8]};
    cur_pos   = '0;
    skip_n    = '0;
    grp_m1    = '0;
    n         = '0;
    recs[0]   = '0;
    recs[1]   = '0;
    tmp       = '0;
    bnd       = 1'b0;
    item_done = 1'b0;
    next_grp  = 1'b0;
    flt       = 1'b0;
    flt_code  = ERR_ODD_USED;
    flt_pos   = '0;

    // A buffer end held over from the previous word goes out first.
    if (pending_q) begin
      tmp         = base_rec(KIND_BUF_DONE, events_done_q);
      tmp.word_a  = held_bufnum_q;
      recs[n[0]]  = tmp;
      n           = n + 2'd1;
      pending_d   = 1'b0;
    end

    // A first word restarts the walk from a clean state.
    if (first_word_i) begin
      phase_d       = PH_HEAD;
      word_index_d  = '0;
      used_words_d  = '0;
      skip_left_d   = '0;
      hit_mask_d    = '0;
      mask_group_d  = '0;
      held_energy_d = '0;
      held_evn_d    = '0;
      held_time_d   = '0;
      held_us_d     = '0;
      held_clock_d  = '0;
      held_bufnum_d = '0;
      events_done_d = '0;
      pending_d     = 1'b0;
    end

    if (phase_d != PH_IDLE) begin
      cur_pos      = word_index_d;
      word_index_d = word_index_d + 16'd1;

      unique case (phase_d)
        PH_HEAD: begin
          if (cur_pos == 16'd0) begin
            if (w[0]) begin
              flt = 1'b1; flt_code = ERR_ODD_USED; flt_pos = cur_pos;
            end else begin
              used_words_d = {1'b0, w[15:1]};
            end
          end else if (cur_pos == 16'd1) begin
            if (raw_word_i != BUF_TYPE) begin
              flt = 1'b1; flt_code = ERR_BUF_TYPE; flt_pos = cur_pos;
            end
          end else if (cur_pos == 16'd2) begin
            held_bufnum_d = {w, 16'h0000};
          end else begin
            held_bufnum_d = {held_bufnum_d[31:16], w};
            bnd           = 1'b1;
          end
        end
        PH_LEN: begin
          if (w == 16'd0) begin
            flt = 1'b1; flt_code = ERR_ZERO_LEN; flt_pos = cur_pos;
          end else if (w[0]) begin
            flt = 1'b1; flt_code = ERR_ODD_LEN; flt_pos = cur_pos;
          end else begin
            skip_left_d = w;
            phase_d     = PH_ID;
          end
        end
        PH_ID: begin
          if (w == ID_CLOCK) begin
            if (skip_left_d != CLOCK_LEN) begin
              flt = 1'b1; flt_code = ERR_CLOCK_LEN; flt_pos = cur_pos - 16'd1;
            end else begin
              phase_d = PH_CLK0;
            end
          end else if (w[15:8] == ID_SYNC || w[15:8] == ID_SCALER ||
                       w[15:8] == ID_SKIP70 || w[15:8] == ID_SKIP74 ||
                       w[15:8] == ID_START) begin
            // Skip the body, clamping a short length at zero.
            skip_n = {1'b0, skip_left_d[15:1]};
            skip_n = (skip_n > 16'd2) ? skip_n - 16'd2 : 16'd0;
            if (skip_n == 16'd0) begin
              bnd = 1'b1;
            end else begin
              skip_left_d = skip_n;
              phase_d     = PH_SKIP;
            end
          end else if (w[15:8] == ID_HIT) begin
            phase_d = PH_EVN0;
          end else begin
            flt = 1'b1; flt_code = ERR_UNKNOWN_ID; flt_pos = cur_pos;
          end
        end
        PH_CLK0: begin
          held_clock_d = {w, 16'h0000};
          phase_d      = PH_CLK1;
        end
        PH_CLK1: begin
          held_clock_d = {held_clock_d[31:16], w};
          phase_d      = PH_CLK2;
        end
        PH_CLK2: begin
          held_energy_d = w;
          phase_d       = PH_CLK3;
        end
        PH_CLK3: begin
          tmp        = base_rec(KIND_CLOCK, events_done_d);
          tmp.word_a = held_clock_d;
          tmp.word_b = {held_energy_d, w};
          recs[n[0]] = tmp;
          n          = n + 2'd1;
          bnd        = 1'b1;
        end
        PH_SKIP: begin
          skip_left_d = skip_left_d - 16'd1;
          if (skip_left_d == 16'd0) begin
            bnd = 1'b1;
          end
        end
        PH_EVN0: begin
          held_evn_d = {w, 16'h0000};
          phase_d    = PH_EVN1;
        end
        PH_EVN1: begin
          held_evn_d = {held_evn_d[31:16], w};
          phase_d    = PH_T0;
        end
        PH_T0: begin
          held_time_d = {held_time_d[47:0], w};
          phase_d     = PH_T1;
        end
        PH_T1: begin
          held_time_d = {held_time_d[47:0], w};
          phase_d     = PH_T2;
        end
        PH_T2: begin
          held_time_d = {held_time_d[47:0], w};
          phase_d     = PH_T3;
        end
        PH_T3: begin
          held_time_d = {held_time_d[47:0], w};
          phase_d     = PH_USM;
        end
        PH_USM: begin
          if (!marker_ok(w)) begin
            flt = 1'b1; flt_code = ERR_US_MARKER; flt_pos = cur_pos;
          end else begin
            phase_d = PH_UST;
          end
        end
        PH_UST: begin
          held_us_d    = w;
          mask_group_d = '0;
          phase_d      = PH_GMARK;
        end
        PH_GMARK: begin
          if (!marker_ok(w)) begin
            flt = 1'b1; flt_code = mask_code(mask_group_d); flt_pos = cur_pos;
          end else begin
            phase_d = PH_GMASK;
          end
        end
        PH_GMASK: begin
          hit_mask_d = w;
          if (w != 16'd0) begin
            phase_d = PH_IMARK;
          end else begin
            next_grp = 1'b1;
          end
        end
        PH_IMARK: begin
          if (!marker_ok(w)) begin
            flt = 1'b1; flt_code = item_code(mask_group_d); flt_pos = cur_pos;
          end else begin
            phase_d = PH_IWORD;
          end
        end
        PH_IWORD: begin
          if (mask_group_d == 2'd0) begin
            held_energy_d = w;
            phase_d       = PH_IMARK2;
          end else begin
            // Silicon groups are offset by 16 channels each.
            grp_m1          = mask_group_d - 2'd1;
            tmp             = base_rec(KIND_SI_HIT, events_done_d);
            tmp.detector_id = {2'b00, w[15:12]} + {grp_m1, 4'b0000};
            tmp.energy      = {4'b0000, w[11:0] & LOW12_MASK};
            recs[n[0]]      = tmp;
            n               = n + 2'd1;
            item_done       = 1'b1;
          end
        end
        PH_IMARK2: begin
          if (!marker_ok(w)) begin
            flt = 1'b1; flt_code = ERR_GE_TIME_MARKER; flt_pos = cur_pos;
          end else begin
            phase_d = PH_IWORD2;
          end
        end
        PH_IWORD2: begin
          tmp             = base_rec(KIND_GE_HIT, events_done_d);
          tmp.detector_id = {2'b00, w[15:12]};
          tmp.energy      = held_energy_d;
          tmp.hit_time    = w[11:0] & LOW12_MASK;
          recs[n[0]]      = tmp;
          n               = n + 2'd1;
          item_done       = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      // Clear the lowest mask bit; an empty mask closes the group.
      if (item_done) begin
        hit_mask_d = hit_mask_d & (hit_mask_d - 16'd1);
        if (hit_mask_d != 16'd0) begin
          phase_d = PH_IMARK;
        end else begin
          next_grp = 1'b1;
        end
      end

      // Move to the next group, or finish the event after the last one.
      if (next_grp) begin
        if (mask_group_d < 2'd3) begin
          mask_group_d = mask_group_d + 2'd1;
          phase_d      = PH_GMARK;
        end else begin
          events_done_d   = events_done_d + 16'd1;
          tmp             = base_rec(KIND_EVENT, events_done_d);
          tmp.word_a      = held_evn_d;
          tmp.event_stamp = held_time_d;
          tmp.micro_time  = held_us_d;
          recs[n[0]]      = tmp;
          n               = n + 2'd1;
          bnd             = 1'b1;
        end
      end

      // A fault reports the word and stops the walk.
      if (flt) begin
        tmp                = base_rec(KIND_ERROR, events_done_d);
        tmp.word_a         = held_bufnum_d;
        tmp.error_code     = flt_code;
        tmp.error_position = flt_pos;
        recs[n[0]]         = tmp;
        n                  = n + 2'd1;
        phase_d            = PH_IDLE;
      end

      // Event boundary, then the buffer end from the length or the last word.
      if (bnd) begin
        phase_d = PH_LEN;
      end
      if ((bnd && word_index_d >= used_words_d) ||
          (final_word_i && phase_d != PH_IDLE)) begin
        phase_d = PH_IDLE;
        if (n < 2'd2) begin
          tmp        = base_rec(KIND_BUF_DONE, events_done_d);
          tmp.word_a = held_bufnum_d;
          recs[n[0]] = tmp;
          n          = n + 2'd1;
        end else begin
          pending_d = 1'b1;
        end
      end
    end

    // Mark the last record of this word.
    if (n == 2'd1) begin
      recs[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      recs[1].last_of_run = 1'b1;
    end
  end

  assign push_o.count = step_i ? n : 2'd0;
  assign push_o.slot0 = recs[0];
  assign push_o.slot1 = recs[1];

  // Walk state advances only on a step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      word_index_q  <= '0;
      used_words_q  <= '0;
      skip_left_q   <= '0;
      hit_mask_q    <= '0;
      mask_group_q  <= '0;
      held_energy_q <= '0;
      held_evn_q    <= '0;
      held_time_q   <= '0;
      held_us_q     <= '0;
      held_clock_q  <= '0;
      held_bufnum_q <= '0;
      events_done_q <= '0;
      pending_q     <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      word_index_q  <= word_index_d;
      used_words_q  <= used_words_d;
      skip_left_q   <= skip_left_d;
      hit_mask_q    <= hit_mask_d;
      mask_group_q  <= mask_group_d;
      held_energy_q <= held_energy_d;
      held_evn_q    <= held_evn_d;
      held_time_q   <= held_time_d;
      held_us_q     <= held_us_d;
      held_clock_q  <= held_clock_d;
      held_bufnum_q <= held_bufnum_d;
      events_done_q <= events_done_d;
      pending_q     <= pending_d;
    end
  end

  // A held buffer end only exists once the walk has stopped.
  a_pending_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> phase_q == PH_IDLE)
    else $error("buffer end held while walk still active");

  // One word never yields more than two records.
  a_two_records: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> n != 2'd3)
    else $error("more than two records for one word");

endmodule

[sv/daq_buffer_hit_deframer.sv]
// ----------------------------------------------------------------------------
// daq_buffer_hit_deframer: detector readout buffer deframer
// Flow: an accepted word is held in the input register and parsed into up to two
//   records, which are written to the record queue whose head drives the output.
// Throughput: one word per cycle; a word that yields two records hands them out
//   one record at a time, and input stalls while the four-entry record queue holds
//   more than two records.
// Reset: rst_ni clears the walk, the queue and the input register; the walk
//   then waits for a word flagged as first of a buffer.
// ----------------------------------------------------------------------------
module daq_buffer_hit_deframer
  import dfr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input words.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [15:0]  s_axis_tdata_i,   // [15:0] raw_word
  input  logic [0:0]   s_axis_tuser_i,   // [0] first_word
  input  logic         s_axis_tlast_i,   // final_word
  // Result records.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [5:0] detector_id, [21:6] energy, [33:22] hit_time, [65:34] word_a,
  // [97:66] word_b, [161:98] event_stamp, [177:162] micro_time,
  // [181:178] error_code, [197:182] error_position, [213:198] event_count,
  // [215:214] zero
  output logic [215:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // [2:0] record_kind
  output logic         m_axis_tlast_o    // last_of_run
);

  logic             in_valid_q;
  logic [15:0]      in_word_q;
  logic             in_first_q;
  logic             in_final_q;
  logic             step;
  logic             pop;
  logic [CNT_W-1:0] fifo_count;
  push_t            push;
  rec_t             head;

  // Parse when a word is held and the queue has room for two records.
  assign step            = in_valid_q && (fifo_count <= CNT_W'(FIFO_DEPTH - 2));
  assign s_axis_tready_o = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_word_q  <= s_axis_tdata_i;
      in_first_q <= s_axis_tuser_i[0];
      in_final_q <= s_axis_tlast_i;
    end
  end

  dfr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .raw_word_i   (in_word_q),
    .first_word_i (in_first_q),
    .final_word_i (in_final_q),
    .push_o       (push)
  );

  dfr_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  // Output side drains the queue head.
  assign m_axis_tvalid_o = fifo_count != '0;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tuser_o  = head.record_kind;
  assign m_axis_tlast_o  = head.last_of_run;
  assign m_axis_tdata_o  = {2'b00, head.event_count, head.error_position,
                            head.error_code, head.micro_time, head.event_stamp,
                            head.word_b, head.word_a, head.hit_time,
                            head.energy, head.detector_id};

endmodule
